// ===== hw/rtl/mmh2_pkg.sv =====
package mmh2_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 3;

  localparam logic [WORD_W-1:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned       BODY_SHIFT  = 24;
  localparam int unsigned       FIN_SHIFT_A = 13;
  localparam int unsigned       FIN_SHIFT_B = 15;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_WORD_LSB = 0;
  localparam int unsigned IN_CNT_LSB  = IN_WORD_LSB + WORD_W;
  localparam int unsigned IN_KLEN_LSB = IN_CNT_LSB + CNT_W;
  localparam int unsigned IN_USED_W   = IN_KLEN_LSB + WORD_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = 2 * WORD_W;

  // Configuration register indexes
  localparam logic REG_HASH_SEED  = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  // Divider step counter covers one step per dividend bit
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BODY_H,
    ST_BODY_W,
    ST_BODY_K,
    ST_BODY_X,
    ST_TAIL,
    ST_TAIL_X,
    ST_FIN_A,
    ST_FIN_B,
    ST_DIV
  } mmh2_state_t;

  // Keep the valid low bytes of a short last word (1 to 3 bytes)
  function automatic logic [WORD_W-1:0] tail_mask(input logic [1:0] cnt);
    logic [WORD_W-1:0] m;
    case (cnt)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/mmh2_mul.sv =====
module mmh2_mul
  import mmh2_pkg::*;
(
  input  logic              clk,
  input  logic [WORD_W-1:0] op,
  output logic [WORD_W-1:0] prod
);

  // Low word of op times the mix constant, registered
  logic [WORD_W-1:0] prod_next;

  assign prod_next = op * MIX_MUL;

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

// ===== hw/rtl/mmh2_mod.sv =====
module mmh2_mod
  import mmh2_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    dvs;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;

  // Restoring step: shift in one dividend bit, subtract when it fits
  assign trial = {rem, quo[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(WORD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end

  // A zero table size maps every hash to bucket zero
  assign remainder = (dvs == '0) ? '0 : rem;

endmodule

// ===== hw/rtl/murmurhash2_bucket_index.sv =====
// MurmurHash2 bucket index unit. A key streams in as 32-bit words, first byte
// in bits 7..0; tuser marks the first word of a key (the accumulator loads
// hash_seed xor key_length), tlast marks the last word. A word of four bytes
// (byte counts 5..7 act as four) takes the body mix, a word of one to three
// bytes takes the tail path, a word of zero bytes is not mixed. On the last
// word the block finalizes the hash and returns hash_value and bucket_index =
// hash_value mod table_size (0 when table_size is 0). All multiplies by the
// mix constant go through one registered 32-bit multiplier under a small
// sequencer, and the modulo runs in a one-bit-per-cycle restoring divider.
// A full word runs the body mix states and a tail word the tail states; a last
// word then runs the finalize states FIN_A and FIN_B and the divider before the
// result is registered. The input is ready only while the sequencer is idle;
// the result waits in an output register while the next request is taken.
// Write configuration only while the block is idle.
module murmurhash2_bucket_index
  import mmh2_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data,
  // key word requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // data_word, byte_count, key_length, zero pad
  input  logic                  s_axis_tuser,  // first_word
  input  logic                  s_axis_tlast,  // last_word
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // hash_value, bucket_index
);

  mmh2_state_t state, state_next;

  logic [WORD_W-1:0] hash_seed;
  logic [WORD_W-1:0] table_size;

  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] tmp, tmp_next;
  logic [WORD_W-1:0] word;
  logic [1:0]        cnt_lo;
  logic              last;
  logic [WORD_W-1:0] hash_fin, hash_fin_next;

  logic [WORD_W-1:0] out_hash;
  logic [WORD_W-1:0] out_bucket;

  logic [WORD_W-1:0] in_word;
  logic [CNT_W-1:0]  in_cnt;
  logic [WORD_W-1:0] in_klen;
  logic              in_take;
  logic              in_full;
  logic              in_zero;

  logic [WORD_W-1:0] mul_op;
  logic [WORD_W-1:0] mul_prod;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;
  logic              out_load;

  assign in_word = s_axis_tdata[IN_WORD_LSB +: WORD_W];
  assign in_cnt  = s_axis_tdata[IN_CNT_LSB  +: CNT_W];
  assign in_klen = s_axis_tdata[IN_KLEN_LSB +: WORD_W];
  assign in_full = in_cnt[CNT_W-1];
  assign in_zero = (in_cnt == '0);

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {out_bucket, out_hash};

  mmh2_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (mul_prod)
  );

  mmh2_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hash_fin_next),
    .divisor   (table_size),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Sequencer: the multiply steps feed the shared multiplier, result in the next cycle
  always_comb begin
    state_next    = state;
    acc_next      = acc;
    tmp_next      = tmp;
    hash_fin_next = hash_fin;
    mul_op        = acc;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (s_axis_tuser) begin
            acc_next = hash_seed ^ in_klen;
          end
          if (in_full) begin
            state_next = ST_BODY_H;
          end else if (!in_zero) begin
            state_next = ST_TAIL;
          end else if (s_axis_tlast) begin
            state_next = ST_FIN_A;
          end
        end
      end
      ST_BODY_H: begin
        mul_op     = acc;
        state_next = ST_BODY_W;
      end
      ST_BODY_W: begin
        // hold h*M while the key word goes through
        tmp_next   = mul_prod;
        mul_op     = word;
        state_next = ST_BODY_K;
      end
      ST_BODY_K: begin
        mul_op     = mul_prod ^ (mul_prod >> BODY_SHIFT);
        state_next = ST_BODY_X;
      end
      ST_BODY_X: begin
        acc_next   = tmp ^ mul_prod;
        state_next = last ? ST_FIN_A : ST_IDLE;
      end
      ST_TAIL: begin
        mul_op     = acc ^ (word & tail_mask(cnt_lo));
        state_next = ST_TAIL_X;
      end
      ST_TAIL_X: begin
        acc_next   = mul_prod;
        state_next = last ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        mul_op     = acc ^ (acc >> FIN_SHIFT_A);
        state_next = ST_FIN_B;
      end
      ST_FIN_B: begin
        hash_fin_next = mul_prod ^ (mul_prod >> FIN_SHIFT_B);
        div_start     = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        // hold until the divider is done and the output register is free
        if (div_done && (!m_axis_tvalid || m_axis_tready)) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed  <= '0;
      table_size <= WORD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HASH_SEED:  hash_seed  <= cfg_data;
        REG_TABLE_SIZE: table_size <= cfg_data;
        default:        hash_seed  <= hash_seed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  // Register tmp and hash_fin, and capture the request payload on accept
  always_ff @(posedge clk) begin
    tmp      <= tmp_next;
    hash_fin <= hash_fin_next;
    if (in_take) begin
      word   <= in_word;
      cnt_lo <= in_cnt[1:0];
      last   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hash   <= hash_fin;
      out_bucket <= div_rem;
    end
  end

  // A last word always keeps the block busy for at least the next cycle
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready right after a last word");

  // The divider drops done as soon as a new hash is handed over
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider done held across a new start");

  // A result only appears after the divider has finished
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DIV && div_done))
    else $error("result raised without a finished division");

endmodule
